>>> hdl/ssched_pkg.sv
// ----------------------------------------------------------------------------
// ssched_pkg
// Types and constants shared by the steering speed scheduler.
// ----------------------------------------------------------------------------
package ssched_pkg;

    localparam int TURN_LIMIT_MAX  = 1000;
    localparam int GATE_MARGIN     = 0;
    localparam int MIN_WHEEL_SPEED = 0;
    localparam int SPEED_TUNE_MAX  = 4095;

    localparam int SPD_W  = 12;
    localparam int DUTY_W = 14;
    localparam int IDX_W  = 3;
    localparam int TW     = $clog2(TURN_LIMIT_MAX + 1);
    localparam int QW     = SPD_W;
    localparam int N1_W   = SPD_W + 2 * TW;
    localparam int D1_W   = 2 * TW;
    localparam int N2_W   = SPD_W + TW;
    localparam int D2_W   = TW;
    localparam int SW     = SPD_W + 3;

    localparam logic [IDX_W-1:0] REG_SPEED_FLOOR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPEED_CEILING = 3'd1;
    localparam logic [IDX_W-1:0] REG_SAFETY_MODE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SAFETY_CAP    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SERVO_CENTER  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SERVO_MIN     = 3'd5;
    localparam logic [IDX_W-1:0] REG_SERVO_MAX     = 3'd6;
    localparam logic [IDX_W-1:0] REG_DIFF_GAIN     = 3'd7;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CAPPED = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;
    // unused encoding, behaves as normal
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    typedef struct packed {
        logic          high;
        logic [TW-1:0] turn;
        logic [TW-1:0] lim;
    } front_t;

    typedef struct packed {
        logic                 high;
        logic                 limz;
        logic [TW-1:0]        turn;
        logic [SPD_W+TW-1:0]  st;
        logic [D1_W-1:0]      d1;
        logic [N2_W-1:0]      n2;
        logic [D2_W-1:0]      d2;
    } prod_t;

    typedef struct packed {
        logic             high;
        logic             limz;
        logic [N1_W-1:0]  r1;
        logic [D1_W-1:0]  d1;
        logic [QW-1:0]    q1;
        logic [N2_W-1:0]  r2;
        logic [D2_W-1:0]  d2;
        logic [QW-1:0]    q2;
    } div_t;

endpackage

>>> hdl/steering_speed_scheduler.sv
// ----------------------------------------------------------------------------
// steering_speed_scheduler
// Turns a servo duty sample into base and left/right wheel target speeds.
// ----------------------------------------------------------------------------
// usage: a servo_duty transaction on in_valid/in_ready yields one result
// transaction (base_speed, left_wheel, right_wheel, stopped) on
// out_valid/out_ready, in order.
// stages: input decode, two multiplier stages, twelve restoring divider
// stages (one quotient bit each, both divisions side by side) and the
// output register. one sample can enter every cycle unless the output stalls.
// registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
// and cfg_data; the user makes writes only with the pipeline empty (unchecked).
// reset clears all valid bits and loads the register defaults.
// when the receiver stalls, the whole pipeline holds and in_ready drops
// for as long as the output register is full and out_ready is low.
// ----------------------------------------------------------------------------
module steering_speed_scheduler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssched_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ssched_pkg::DUTY_W-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ssched_pkg::DUTY_W-1:0]    servo_duty,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ssched_pkg::SPD_W-1:0]     base_speed,
    output logic [ssched_pkg::SPD_W-1:0]     left_wheel,
    output logic [ssched_pkg::SPD_W-1:0]     right_wheel,
    output logic                             stopped
);

    localparam int SPD_W  = ssched_pkg::SPD_W;
    localparam int DUTY_W = ssched_pkg::DUTY_W;
    localparam int TW     = ssched_pkg::TW;
    localparam int QW     = ssched_pkg::QW;
    localparam int N1_W   = ssched_pkg::N1_W;
    localparam int N2_W   = ssched_pkg::N2_W;
    localparam int SW     = ssched_pkg::SW;

    logic [SPD_W-1:0]  speed_floor_reg;
    logic [SPD_W-1:0]  speed_ceiling_reg;
    logic [1:0]        safety_mode_reg;
    logic [SPD_W-1:0]  safety_cap_reg;
    logic [DUTY_W-1:0] servo_center_reg;
    logic [DUTY_W-1:0] servo_min_reg;
    logic [DUTY_W-1:0] servo_max_reg;
    logic [SPD_W-1:0]  diff_gain_reg;

    logic adv;

    ssched_pkg::front_t front_reg, front_next;
    logic               front_vld_reg;
    ssched_pkg::prod_t  prod_reg, prod_next;
    logic               prod_vld_reg;
    ssched_pkg::div_t   div_reg [0:QW];
    ssched_pkg::div_t   div_next [0:QW];
    logic [QW:0]        div_vld_reg;

    logic [SPD_W-1:0] base_reg, base_next;
    logic [SPD_W-1:0] left_reg, left_next;
    logic [SPD_W-1:0] right_reg, right_next;
    logic             stopped_reg, stopped_next;
    logic             out_vld_reg;

    // derived speed limits; the user keeps them static while items are in flight
    logic signed [SW-1:0] ceil_s, flr_s, span_s, oc_s;

    assign cfg_ready = 1'b1;
    assign adv       = !out_vld_reg || out_ready;
    assign in_ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_floor_reg   <= '0;
            speed_ceiling_reg <= SPD_W'(1000);
            safety_mode_reg   <= ssched_pkg::MODE_NORMAL;
            safety_cap_reg    <= '0;
            servo_center_reg  <= DUTY_W'(8192);
            servo_min_reg     <= DUTY_W'(7192);
            servo_max_reg     <= DUTY_W'(9192);
            diff_gain_reg     <= SPD_W'(200);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ssched_pkg::REG_SPEED_FLOOR:   speed_floor_reg   <= cfg_data[SPD_W-1:0];
                ssched_pkg::REG_SPEED_CEILING: speed_ceiling_reg <= cfg_data[SPD_W-1:0];
                ssched_pkg::REG_SAFETY_MODE:   safety_mode_reg   <= cfg_data[1:0];
                ssched_pkg::REG_SAFETY_CAP:    safety_cap_reg    <= cfg_data[SPD_W-1:0];
                ssched_pkg::REG_SERVO_CENTER:  servo_center_reg  <= cfg_data;
                ssched_pkg::REG_SERVO_MIN:     servo_min_reg     <= cfg_data;
                ssched_pkg::REG_SERVO_MAX:     servo_max_reg     <= cfg_data;
                ssched_pkg::REG_DIFF_GAIN:     diff_gain_reg     <= cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ceil_s = SW'($signed({1'b0, speed_ceiling_reg}));
        if (ceil_s < SW'(ssched_pkg::MIN_WHEEL_SPEED))
            ceil_s = SW'(ssched_pkg::MIN_WHEEL_SPEED);
        if (ceil_s > SW'(ssched_pkg::SPEED_TUNE_MAX))
            ceil_s = SW'(ssched_pkg::SPEED_TUNE_MAX);
        flr_s = SW'($signed({1'b0, speed_floor_reg}));
        if (flr_s < SW'(ssched_pkg::MIN_WHEEL_SPEED))
            flr_s = SW'(ssched_pkg::MIN_WHEEL_SPEED);
        else if (flr_s > ceil_s)
            flr_s = ceil_s;
        span_s = ceil_s - flr_s;
        if (span_s < 0)
            span_s = '0;
        oc_s = ceil_s - SW'(ssched_pkg::GATE_MARGIN);
        if (safety_mode_reg == ssched_pkg::MODE_CAPPED
            && SW'($signed({1'b0, safety_cap_reg})) < oc_s)
            oc_s = SW'($signed({1'b0, safety_cap_reg}));
        if (oc_s < SW'(ssched_pkg::MIN_WHEEL_SPEED))
            oc_s = SW'(ssched_pkg::MIN_WHEEL_SPEED);
        if (oc_s > SW'(ssched_pkg::SPEED_TUNE_MAX))
            oc_s = SW'(ssched_pkg::SPEED_TUNE_MAX);
    end

    // stage 0: side, offset and travel limit
    always_comb
    begin
        logic [DUTY_W-1:0]     turn_raw;
        logic signed [DUTY_W+1:0] lim_raw;
        front_next.high = servo_duty > servo_center_reg;
        if (front_next.high)
        begin
            turn_raw = servo_duty - servo_center_reg;
            lim_raw  = $signed({2'b00, servo_max_reg}) - $signed({2'b00, servo_center_reg});
        end
        else
        begin
            turn_raw = servo_center_reg - servo_duty;
            lim_raw  = $signed({2'b00, servo_center_reg}) - $signed({2'b00, servo_min_reg});
        end
        if (lim_raw < 0)
            lim_raw = '0;
        if (lim_raw > (DUTY_W+2)'(ssched_pkg::TURN_LIMIT_MAX))
            lim_raw = (DUTY_W+2)'(ssched_pkg::TURN_LIMIT_MAX);
        front_next.lim = TW'(lim_raw);
        if ({2'b00, turn_raw} > lim_raw)
            front_next.turn = TW'(lim_raw);
        else
            front_next.turn = TW'(turn_raw);
    end

    // stage 1: first products
    always_comb
    begin
        prod_next.high = front_reg.high;
        prod_next.limz = front_reg.lim == '0;
        prod_next.turn = front_reg.turn;
        prod_next.st   = SPD_W'(span_s) * front_reg.turn;
        prod_next.d1   = front_reg.lim * front_reg.lim;
        prod_next.n2   = diff_gain_reg * front_reg.turn;
        prod_next.d2   = front_reg.lim;
    end

    // stage 2 and divider stages, one quotient bit per stage
    always_comb
    begin
        logic [N1_W-1:0] sh1;
        logic [N2_W-1:0] sh2;
        div_next[0].high = prod_reg.high;
        div_next[0].limz = prod_reg.limz;
        div_next[0].r1   = prod_reg.st * prod_reg.turn;
        div_next[0].d1   = prod_reg.d1;
        div_next[0].q1   = '0;
        div_next[0].r2   = prod_reg.n2;
        div_next[0].d2   = prod_reg.d2;
        div_next[0].q2   = '0;
        for (int i = 0; i < QW; i++)
        begin
            div_next[i+1] = div_reg[i];
            sh1 = N1_W'(div_reg[i].d1) << (QW - 1 - i);
            sh2 = N2_W'(div_reg[i].d2) << (QW - 1 - i);
            if (div_reg[i].r1 >= sh1)
            begin
                div_next[i+1].r1 = div_reg[i].r1 - sh1;
                div_next[i+1].q1[QW-1-i] = 1'b1;
            end
            if (div_reg[i].r2 >= sh2)
            begin
                div_next[i+1].r2 = div_reg[i].r2 - sh2;
                div_next[i+1].q2[QW-1-i] = 1'b1;
            end
        end
    end

    // output stage: gating, differential, wheel clamps and forced stop
    always_comb
    begin
        logic signed [SW-1:0] sched, tar, diff, lft, rgt;
        if (div_reg[QW].limz)
        begin
            sched = ceil_s;
            diff  = '0;
        end
        else
        begin
            sched = ceil_s - SW'($signed({1'b0, div_reg[QW].q1}));
            diff  = SW'($signed({1'b0, div_reg[QW].q2}));
        end
        tar = (sched > oc_s) ? oc_s : sched;
        if (div_reg[QW].high)
        begin
            lft = tar + diff;
            rgt = tar - diff;
        end
        else
        begin
            lft = tar - diff;
            rgt = tar + diff;
        end
        if (lft > oc_s)
            lft = oc_s;
        else if (lft < SW'(ssched_pkg::MIN_WHEEL_SPEED))
            lft = SW'(ssched_pkg::MIN_WHEEL_SPEED);
        if (rgt > oc_s)
            rgt = oc_s;
        else if (rgt < SW'(ssched_pkg::MIN_WHEEL_SPEED))
            rgt = SW'(ssched_pkg::MIN_WHEEL_SPEED);
        if (safety_mode_reg == ssched_pkg::MODE_STOP)
        begin
            base_next    = '0;
            left_next    = '0;
            right_next   = '0;
            stopped_next = 1'b1;
        end
        else
        begin
            base_next    = (tar < 0) ? '0 : SPD_W'(tar);
            left_next    = (lft < 0) ? '0 : SPD_W'(lft);
            right_next   = (rgt < 0) ? '0 : SPD_W'(rgt);
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
            div_vld_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else if (adv)
        begin
            front_vld_reg <= in_valid;
            prod_vld_reg  <= front_vld_reg;
            div_vld_reg   <= {div_vld_reg[QW-1:0], prod_vld_reg};
            out_vld_reg   <= div_vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg   <= front_next;
            prod_reg    <= prod_next;
            for (int i = 0; i <= QW; i++)
                div_reg[i] <= div_next[i];
            base_reg    <= base_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            stopped_reg <= stopped_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign base_speed   = base_reg;
    assign left_wheel   = left_reg;
    assign right_wheel  = right_reg;
    assign stopped      = stopped_reg;

endmodule

>>> tb/sv/tb_steering_speed_scheduler.sv
// ----------------------------------------------------------------------------
// tb_steering_speed_scheduler
// Drives servo duty samples and register settings into the steering speed
// scheduler and checks every result against an in-bench predictor or table value.
// ----------------------------------------------------------------------------
module tb_steering_speed_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ssched_pkg::SPD_W-1:0] base;
        logic [ssched_pkg::SPD_W-1:0] left;
        logic [ssched_pkg::SPD_W-1:0] right;
        logic                         stop;
    } speeds_t;

    typedef struct {
        logic [ssched_pkg::DUTY_W-1:0] duty;
        logic                          has_ref;
        speeds_t                       ref_val;
    } row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ssched_pkg::IDX_W-1:0]      cfg_index = '0;
    logic [ssched_pkg::DUTY_W-1:0]     cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [ssched_pkg::DUTY_W-1:0]     servo_duty = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [ssched_pkg::SPD_W-1:0]      base_speed, left_wheel, right_wheel;
    logic                              stopped;

    // shadow copies of the block's registers
    logic [11:0] r_floor, r_ceil, r_cap, r_gain;
    logic [1:0]  r_mode;
    logic [13:0] r_center, r_min, r_max;

    speeds_t     pending_speeds[$];
    int          fail_cnt = 0;
    int          send_idle = 9;
    int          recv_idle = 59;

    steering_speed_scheduler u_dut (.*);

    always #4 clk = ~clk;

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic speeds_t schedule_speeds(logic [13:0] duty);
        longint c, turn, lim, ceil_v, flr, oc, sched, tar, diff, lw, rw;
        bit hs;
        speeds_t s;
        c = longint'(r_center);
        hs = duty > r_center;
        s.stop = 1'b0;
        if (r_mode == ssched_pkg::MODE_STOP) begin
            s = '0;
            s.stop = 1'b1;
            return s;
        end
        if (hs) begin
            turn = longint'(duty) - c;
            lim = longint'(r_max) - c;
        end
        else begin
            turn = c - longint'(duty);
            lim = c - longint'(r_min);
        end
        lim = clip(lim, 0, ssched_pkg::TURN_LIMIT_MAX);
        if (turn > lim) turn = lim;
        ceil_v = clip(longint'(r_ceil), ssched_pkg::MIN_WHEEL_SPEED, ssched_pkg::SPEED_TUNE_MAX);
        flr = longint'(r_floor);
        if (flr < ssched_pkg::MIN_WHEEL_SPEED) flr = ssched_pkg::MIN_WHEEL_SPEED;
        else if (flr > ceil_v) flr = ceil_v;
        oc = ceil_v - ssched_pkg::GATE_MARGIN;
        if (r_mode == ssched_pkg::MODE_CAPPED && longint'(r_cap) < oc) oc = longint'(r_cap);
        oc = clip(oc, ssched_pkg::MIN_WHEEL_SPEED, ssched_pkg::SPEED_TUNE_MAX);
        if (lim == 0) begin
            sched = ceil_v;
            diff = 0;
        end
        else begin
            sched = ceil_v - ((ceil_v - flr) * turn * turn) / (lim * lim);
            diff = (longint'(r_gain) * turn) / lim;
        end
        tar = sched > oc ? oc : sched;
        lw = hs ? tar + diff : tar - diff;
        rw = hs ? tar - diff : tar + diff;
        lw = clip(lw, ssched_pkg::MIN_WHEEL_SPEED, oc);
        rw = clip(rw, ssched_pkg::MIN_WHEEL_SPEED, oc);
        s.base = 12'(clip(tar, 0, 4095));
        s.left = 12'(clip(lw, 0, 4095));
        s.right = 12'(clip(rw, 0, 4095));
        return s;
    endfunction

    // valid drops at the negedge after acceptance
    task automatic write_reg(logic [ssched_pkg::IDX_W-1:0] idx, logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            ssched_pkg::REG_SPEED_FLOOR:   r_floor = val[11:0];
            ssched_pkg::REG_SPEED_CEILING: r_ceil = val[11:0];
            ssched_pkg::REG_SAFETY_MODE:   r_mode = val[1:0];
            ssched_pkg::REG_SAFETY_CAP:    r_cap = val[11:0];
            ssched_pkg::REG_SERVO_CENTER:  r_center = val;
            ssched_pkg::REG_SERVO_MIN:     r_min = val;
            ssched_pkg::REG_SERVO_MAX:     r_max = val;
            default:                       r_gain = val[11:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_speeds.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    // one servo transaction; valid stays up across back-to-back items
    task automatic send_duty(logic [13:0] duty, logic has_ref, speeds_t ref_val);
        speeds_t p;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        p = schedule_speeds(duty);
        if (has_ref && p !== ref_val)
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, ref_val, p);
        if (has_ref) p = ref_val;
        in_valid <= 1'b1;
        servo_duty <= duty;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_speeds.push_back(p);
        @(negedge clk);
    endtask

    task automatic random_cfg(bit extreme);
        write_reg(ssched_pkg::REG_SPEED_FLOOR,
                  extreme ? ($urandom_range(1) ? 14'hFFF : 14'd0) : 14'($urandom));
        write_reg(ssched_pkg::REG_SPEED_CEILING,
                  extreme ? ($urandom_range(1) ? 14'hFFF : 14'd0) : 14'($urandom));
        write_reg(ssched_pkg::REG_SAFETY_MODE, 14'($urandom_range(3)));
        write_reg(ssched_pkg::REG_SAFETY_CAP, 14'($urandom));
        write_reg(ssched_pkg::REG_SERVO_CENTER, 14'($urandom_range(4000, 12000)));
        write_reg(ssched_pkg::REG_SERVO_MIN,
                  14'(r_center - $urandom_range(0, 1400) + $urandom_range(0, 200)));
        write_reg(ssched_pkg::REG_SERVO_MAX,
                  14'(r_center + $urandom_range(0, 1400) - $urandom_range(0, 200)));
        write_reg(ssched_pkg::REG_DIFF_GAIN, extreme ? 14'hFFF : 14'($urandom));
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk) begin
        speeds_t got, want;
        if (rst_n && out_valid && out_ready) begin
            got = '{base_speed, left_wheel, right_wheel, stopped};
            if (pending_speeds.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                fail_cnt++;
            end
            else begin
                want = pending_speeds.pop_front();
                if (got.base !== want.base || got.left !== want.left ||
                    got.right !== want.right || got.stop !== want.stop) begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    fail_cnt++;
                end
            end
        end
    end

    row_t dir_rows[$];

    initial begin
        int phase, n;
        logic [13:0] d;
        r_floor = 0; r_ceil = 1000; r_mode = ssched_pkg::MODE_NORMAL; r_cap = 0;
        r_center = 8192; r_min = 7192; r_max = 9192; r_gain = 200;
        // defaults: centre gives ceiling, full lock gives floor and the gain
        dir_rows.push_back('{14'd8192, 1, '{12'd1000, 12'd1000, 12'd1000, 1'b0}});
        dir_rows.push_back('{14'd9192, 1, '{12'd0, 12'd200, 12'd0, 1'b0}});
        dir_rows.push_back('{14'd7192, 1, '{12'd0, 12'd0, 12'd200, 1'b0}});
        dir_rows.push_back('{14'd16383, 1, '{12'd0, 12'd200, 12'd0, 1'b0}});
        dir_rows.push_back('{14'd0, 1, '{12'd0, 12'd0, 12'd200, 1'b0}});
        dir_rows.push_back('{14'd8692, 0, '0});
        dir_rows.push_back('{14'd8193, 0, '0});
        dir_rows.push_back('{14'd8191, 0, '0});
        dir_rows.push_back('{14'd7700, 0, '0});
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (dir_rows[i]) send_duty(dir_rows[i].duty, dir_rows[i].has_ref, dir_rows[i].ref_val);
        in_valid <= 1'b0;
        drain();
        // forced stop
        write_reg(ssched_pkg::REG_SAFETY_MODE, 14'(ssched_pkg::MODE_STOP));
        send_duty(14'd0, 1, '{12'd0, 12'd0, 12'd0, 1'b1});
        send_duty(14'h3FFF, 1, '{12'd0, 12'd0, 12'd0, 1'b1});
        in_valid <= 1'b0;
        drain();
        // capped mode, inverted travel, zero turn limit, unused mode
        write_reg(ssched_pkg::REG_SAFETY_MODE, 14'(ssched_pkg::MODE_CAPPED));
        write_reg(ssched_pkg::REG_SAFETY_CAP, 14'd300);
        write_reg(ssched_pkg::REG_SPEED_FLOOR, 14'hFFF);
        write_reg(ssched_pkg::REG_SPEED_CEILING, 14'hFFF);
        write_reg(ssched_pkg::REG_DIFF_GAIN, 14'hFFF);
        write_reg(ssched_pkg::REG_SERVO_MAX, 14'd100);
        write_reg(ssched_pkg::REG_SERVO_MIN, 14'h3FFF);
        send_duty(14'd8192, 1, '{12'd300, 12'd300, 12'd300, 1'b0});
        send_duty(14'h3FFF, 1, '{12'd300, 12'd300, 12'd300, 1'b0});
        send_duty(14'd0, 1, '{12'd300, 12'd300, 12'd300, 1'b0});
        in_valid <= 1'b0;
        drain();
        write_reg(ssched_pkg::REG_SAFETY_MODE, 14'(ssched_pkg::MODE_SPARE));
        write_reg(ssched_pkg::REG_SERVO_MIN, 14'd0);
        write_reg(ssched_pkg::REG_SERVO_MAX, 14'h3FFF);
        write_reg(ssched_pkg::REG_SPEED_FLOOR, 14'd0);
        send_duty(14'd9000, 0, '0);
        send_duty(14'd7000, 0, '0);
        send_duty(14'd1, 0, '0);
        in_valid <= 1'b0;
        drain();
        for (phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 9 : (phase == 1) ? 59 : 0;
            recv_idle = (phase == 0) ? 59 : (phase == 1) ? 9 : 0;
            for (n = 0; n < 5; n++) begin
                random_cfg(n == 0);
                repeat (57) begin
                    case ($urandom_range(3))
                        0: d = 14'($urandom);
                        1: d = 14'(r_center + $urandom_range(0, 1500) - $urandom_range(0, 1500));
                        2: d = $urandom_range(1) ? r_min : r_max;
                        default: d = 14'(r_center + $urandom_range(0, 2) - 1);
                    endcase
                    send_duty(d, 0, '0);
                end
                in_valid <= 1'b0;
                drain();
            end
        end
        if (pending_speeds.size() != 0) begin
            $display("%0t results missing: expected %0d actual 0", $time, pending_speeds.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> files.f
hdl/ssched_pkg.sv
hdl/steering_speed_scheduler.sv
tb/sv/tb_steering_speed_scheduler.sv
